// ===== src/pal_pdl_pkg.sv =====
// Package: shared constants and types of the PAL chroma delay line.
`default_nettype none
package pal_pdl_pkg;

   // Line store geometry
   localparam int MaxLineWidth = 512;
   localparam int ColW         = $clog2(MaxLineWidth);
   localparam int EffW         = ColW + 1;

   // Field and word widths
   localparam int ByteW        = 8;
   localparam int ChromaW      = 2 * ByteW;
   localparam int WordW        = 3 * ByteW;
   localparam int IndexW       = 4;
   localparam int PalDepth     = 2 << IndexW;

   // Configuration port
   localparam int LwW          = 10;
   localparam int CmpW         = (LwW > EffW) ? LwW : EffW;
   localparam int CsrAddrW     = 1;
   localparam int CsrDataW     = LwW;
   localparam logic [CsrAddrW-1:0] CsrPalMode   = 1'b0;
   localparam logic [CsrAddrW-1:0] CsrLineWidth = 1'b1;
   localparam logic               PalModeReset   = 1'b1;
   localparam logic [LwW-1:0]     LineWidthReset = 10'd384;

   // Item operation codes
   localparam logic OpPixel = 1'b0;
   localparam logic OpTable = 1'b1;

   // Pixel waiting for its memory reads
   typedef struct packed {
      logic [ColW-1:0]    col;
      logic               avg;
      logic               fwd;
      logic [ChromaW-1:0] fwd_chroma;
   } pal_pdl_s1_type;

endpackage
`default_nettype wire

// ===== src/pal_pdl_req_if.sv =====
// Interfaces: request and response channels of the PAL chroma delay line.
`default_nettype none
interface pal_pdl_req_if;
   import pal_pdl_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [IndexW-1:0] pixel_index;
   logic              start_of_frame;
   logic              table_half;
   logic [IndexW-1:0] table_entry;
   logic [WordW-1:0]  table_word;

   modport source (output valid, op, pixel_index, start_of_frame, table_half,
                   table_entry, table_word, input ready);
   modport sink   (input valid, op, pixel_index, start_of_frame, table_half,
                   table_entry, table_word, output ready);
endinterface

interface pal_pdl_rsp_if;
   import pal_pdl_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] luma;
   logic [ByteW-1:0] chroma_u;
   logic [ByteW-1:0] chroma_v;

   modport source (output valid, luma, chroma_u, chroma_v, input ready);
   modport sink   (input valid, luma, chroma_u, chroma_v, output ready);
endinterface
`default_nettype wire

// ===== src/pal_palette_chroma_delay_line_core.sv =====
// Top level: palette lookup with PAL chroma averaging against the line above.
//
//  channel | dir | fields                                         | handshake
//  --------+-----+------------------------------------------------+-------------
//  req_ch  | in  | op pixel_index start_of_frame table_half       | valid/ready
//          |     | table_entry table_word                         |
//  rsp_ch  | out | luma chroma_u chroma_v                         | valid/ready
//  csr_*   | in  | csr_we csr_addr csr_wdata                      | write enable
//
//  One item per cycle while the output is not stalled. A pixel item's result
//  passes through the read stage (palette and line store reads) and then the
//  output register. A palette write item returns nothing.
//  Reset clears the line position and the configuration; the memories are
//  not cleared. A stalled output holds the pixel behind it in the read stage,
//  and the input stalls only while both stages are full.
`default_nettype none
module pal_palette_chroma_delay_line_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pal_pdl_req_if.sink                        req_ch,
   pal_pdl_rsp_if.source                      rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [pal_pdl_pkg::CsrAddrW-1:0] csr_addr,
   input  wire logic [pal_pdl_pkg::CsrDataW-1:0] csr_wdata
);
   import pal_pdl_pkg::*;

   // Configuration
   logic           pal_mode_ff;
   logic [LwW-1:0] line_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_mode_ff   <= PalModeReset;
         line_width_ff <= LineWidthReset;
      end else if (csr_we) begin
         case (csr_addr)
            CsrPalMode:   pal_mode_ff   <= csr_wdata[0];
            CsrLineWidth: line_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the line width into 1 .. MaxLineWidth
   logic [CmpW-1:0] eff_cmp;
   logic [EffW-1:0] eff_width;

   always_comb begin
      if (line_width_ff == '0) begin
         eff_cmp = CmpW'(1);
      end else if (CmpW'(line_width_ff) > CmpW'(MaxLineWidth)) begin
         eff_cmp = CmpW'(MaxLineWidth);
      end else begin
         eff_cmp = CmpW'(line_width_ff);
      end
      eff_width = EffW'(eff_cmp);
   end

   // Pipeline control
   logic           s1_valid_ff, s1_valid_in;
   logic           s2_valid_ff, s2_valid_in;
   logic           s1_adv;
   logic           req_acc, pix_acc, tbl_acc;
   pal_pdl_s1_type s1_ff, s1_in;

   assign s1_adv       = s1_valid_ff && (!s2_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign pix_acc      = req_acc && (req_ch.op == OpPixel);
   assign tbl_acc      = req_acc && (req_ch.op == OpTable);

   // Line position; start of frame restarts it before the pixel is used
   logic [ColW-1:0] col_ff, col_in, col_cur;
   logic            odd_ff, odd_in, odd_cur;
   logic            first_ff, first_in, first_cur;
   logic [EffW-1:0] col_next;
   logic            wrap;

   always_comb begin
      if (req_ch.start_of_frame) begin
         col_cur   = '0;
         odd_cur   = 1'b0;
         first_cur = 1'b1;
      end else begin
         col_cur   = col_ff;
         odd_cur   = odd_ff;
         first_cur = first_ff;
      end
      col_next = {1'b0, col_cur} + EffW'(1);
      wrap     = (col_next >= eff_width);
      col_in   = wrap ? '0 : col_next[ColW-1:0];
      odd_in   = odd_cur ^ wrap;
      first_in = first_cur && !wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         odd_ff   <= 1'b0;
         first_ff <= 1'b1;
      end else if (pix_acc) begin
         col_ff   <= col_in;
         odd_ff   <= odd_in;
         first_ff <= first_in;
      end
   end

   // Palette: write on a table item, read on a pixel item
   logic [WordW-1:0]   pal_rdata;
   logic [ChromaW-1:0] ls_rdata;

   pal_pdl_ram #(
      .Depth (PalDepth),
      .Width (WordW)
   ) u_palette (
      .clock (clock),
      .we    (tbl_acc),
      .waddr ({req_ch.table_half, req_ch.table_entry}),
      .wdata (req_ch.table_word),
      .re    (pix_acc),
      .raddr ({odd_cur, req_ch.pixel_index}),
      .rdata (pal_rdata)
   );

   // Line store: read the column at accept, write back the original chroma
   // as the pixel leaves the read stage
   pal_pdl_ram #(
      .Depth (MaxLineWidth),
      .Width (ChromaW)
   ) u_line_store (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_ff.col),
      .wdata (pal_rdata[ChromaW-1:0]),
      .re    (pix_acc),
      .raddr (col_cur),
      .rdata (ls_rdata)
   );

   // Read stage; forward the chroma written in the same cycle to the same column
   always_comb begin
      s1_in.col        = col_cur;
      s1_in.avg        = pal_mode_ff && !first_cur;
      s1_in.fwd        = s1_adv && (s1_ff.col == col_cur);
      s1_in.fwd_chroma = pal_rdata[ChromaW-1:0];
      if (pix_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         s1_ff <= s1_in;
      end
   end

   // Average and output register
   logic [ChromaW-1:0] above;
   logic [ByteW:0]     sum_u, sum_v;
   logic [ByteW-1:0]   luma_ff, luma_in;
   logic [ByteW-1:0]   u_ff, u_in;
   logic [ByteW-1:0]   v_ff, v_in;

   always_comb begin
      above   = s1_ff.fwd ? s1_ff.fwd_chroma : ls_rdata;
      sum_u   = {1'b0, pal_rdata[ChromaW-1:ByteW]} + {1'b0, above[ChromaW-1:ByteW]};
      sum_v   = {1'b0, pal_rdata[ByteW-1:0]} + {1'b0, above[ByteW-1:0]};
      luma_in = pal_rdata[WordW-1:ChromaW];
      u_in    = s1_ff.avg ? sum_u[ByteW:1] : pal_rdata[ChromaW-1:ByteW];
      v_in    = s1_ff.avg ? sum_v[ByteW:1] : pal_rdata[ByteW-1:0];
      if (s1_adv) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         luma_ff <= luma_in;
         u_ff    <= u_in;
         v_ff    <= v_in;
      end
   end

   assign rsp_ch.valid    = s2_valid_ff;
   assign rsp_ch.luma     = luma_ff;
   assign rsp_ch.chroma_u = u_ff;
   assign rsp_ch.chroma_v = v_ff;
endmodule
`default_nettype wire

// ===== src/pal_pdl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module pal_pdl_ram #(
   parameter int Depth = 32,
   parameter int Width = 24,
   parameter int AddrW = $clog2(Depth)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] waddr,
   input  wire logic [Width-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AddrW-1:0] raddr,
   output      logic [Width-1:0] rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== src/pal_pdl_checker.sv =====
// Checker: port-level properties of the PAL chroma delay line.
`default_nettype none
module pal_pdl_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_op,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [pal_pdl_pkg::ByteW-1:0] rsp_luma,
   input wire logic [pal_pdl_pkg::ByteW-1:0] rsp_chroma_u,
   input wire logic [pal_pdl_pkg::ByteW-1:0] rsp_chroma_v
);
   import pal_pdl_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_luma) && $stable(rsp_chroma_u) && $stable(rsp_chroma_v))
      else $error("stalled result changed");

   // An accepted pixel item raises the output valid
   a_pixel_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OpPixel) |-> ##2 rsp_valid)
      else $error("pixel result missing");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind pal_palette_chroma_delay_line_core pal_pdl_checker u_pal_pdl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_op       (req_ch.op),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_luma     (rsp_ch.luma),
   .rsp_chroma_u (rsp_ch.chroma_u),
   .rsp_chroma_v (rsp_ch.chroma_v)
);
`default_nettype wire

// ===== bench/tb_pal_palette_chroma_delay_line_core.sv =====
// Testbench: self-checking random and directed test of the PAL chroma delay line core.
`timescale 1ns / 1ps
`default_nettype none
module tb_pal_palette_chroma_delay_line_core;
   import pal_pdl_pkg::*;

   // One request item as the sender sees it
   typedef struct packed {
      logic              op;
      logic [IndexW-1:0] pixel_index;
      logic              start_of_frame;
      logic              table_half;
      logic [IndexW-1:0] table_entry;
      logic [WordW-1:0]  table_word;
   } palette_req_type;

   // One pixel result
   typedef struct packed {
      logic [ByteW-1:0] luma;
      logic [ByteW-1:0] chroma_u;
      logic [ByteW-1:0] chroma_v;
   } pixel_out_type;

   localparam int SettleCycles = 4;     // two pipeline stages plus margin
   localparam int DrainLimit   = 5000;  // cycles to wait for outstanding pixels

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_we    = 1'b0;
   logic [CsrAddrW-1:0] csr_addr  = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   pal_pdl_req_if req_ch ();
   pal_pdl_rsp_if rsp_ch ();

   pal_palette_chroma_delay_line_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Mirror of the block: palettes, line store, raster position, registers
   logic [WordW-1:0]   palette_mem [PalDepth];
   logic [ChromaW-1:0] line_chroma [MaxLineWidth];
   bit                 line_written [MaxLineWidth];
   int                 col_count   = 0;
   bit                 odd_line    = 1'b0;
   bit                 first_line  = 1'b1;
   bit                 mode_pal    = PalModeReset;
   logic [LwW-1:0]     width_reg   = LineWidthReset;

   pixel_out_type expected_pixels_q [$];
   int            mismatch_count = 0;

   // Idle and stall rates in percent, changed per phase
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int rsp_hold      = 0;

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.op             = OpPixel;
      req_ch.pixel_index    = '0;
      req_ch.start_of_frame = 1'b0;
      req_ch.table_half     = 1'b0;
      req_ch.table_entry    = '0;
      req_ch.table_word     = '0;
      rsp_ch.ready          = 1'b0;
   end

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 12);
      return $urandom_range(3, 1);
   endfunction

   function automatic palette_req_type pixel_item(input logic [IndexW-1:0] idx,
                                                  input logic sof);
      palette_req_type it;
      it.op             = OpPixel;
      it.pixel_index    = idx;
      it.start_of_frame = sof;
      it.table_half     = 1'($urandom);
      it.table_entry    = IndexW'($urandom);
      it.table_word     = WordW'($urandom);
      return it;
   endfunction

   function automatic palette_req_type table_item(input logic half,
                                                  input logic [IndexW-1:0] entry,
                                                  input logic [WordW-1:0] word);
      palette_req_type it;
      it.op             = OpTable;
      it.pixel_index    = IndexW'($urandom);
      it.start_of_frame = 1'($urandom);
      it.table_half     = half;
      it.table_entry    = entry;
      it.table_word     = word;
      return it;
   endfunction

   // Advance the mirror by one accepted item and queue the pixel it yields
   function automatic void predict_chroma_pixel(input palette_req_type it);
      logic [WordW-1:0]   word;
      logic [ChromaW-1:0] above;
      pixel_out_type      res;
      int                 col;
      int                 eff;
      if (it.op == OpTable) begin
         palette_mem[{it.table_half, it.table_entry}] = it.table_word;
         return;
      end
      if (it.start_of_frame) begin
         col_count  = 0;
         odd_line   = 1'b0;
         first_line = 1'b1;
      end
      col = col_count;
      if (col >= MaxLineWidth) col = 0;
      word = palette_mem[{odd_line, it.pixel_index}];
      // Store the unaveraged chroma for the next line, in either mode
      above             = line_chroma[col];
      line_chroma[col]  = word[ChromaW-1:0];
      line_written[col] = 1'b1;
      res.luma     = word[WordW-1:ChromaW];
      res.chroma_u = word[ChromaW-1:ByteW];
      res.chroma_v = word[ByteW-1:0];
      if (mode_pal && !first_line) begin
         // Floor average with the pixel one line above
         res.chroma_u = ByteW'((int'(res.chroma_u) + int'(above[ChromaW-1:ByteW])) >> 1);
         res.chroma_v = ByteW'((int'(res.chroma_v) + int'(above[ByteW-1:0])) >> 1);
      end
      expected_pixels_q.push_back(res);
      // Zero acts as one, anything above the store size as the store size
      eff = (width_reg == 0) ? 1 : ((width_reg > MaxLineWidth) ? MaxLineWidth : int'(width_reg));
      col++;
      if (col >= eff) begin
         col        = 0;
         odd_line   = ~odd_line;
         first_line = 1'b0;
      end
      col_count = col;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
   endtask

   // Send one item: called and returns at a falling edge
   task automatic send_item(input palette_req_type it);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      // Never let a pixel average against a line store column no pixel has filled;
      // restart the frame there instead
      if (it.op == OpPixel && !it.start_of_frame && mode_pal && !first_line &&
          !line_written[col_count])
         it.start_of_frame = 1'b1;
      req_ch.valid          = 1'b1;
      req_ch.op             = it.op;
      req_ch.pixel_index    = it.pixel_index;
      req_ch.start_of_frame = it.start_of_frame;
      req_ch.table_half     = it.table_half;
      req_ch.table_entry    = it.table_entry;
      req_ch.table_word     = it.table_word;
      // Hold the item until the block takes it
      do @(posedge clock); while (!req_ch.ready);
      predict_chroma_pixel(it);
      @(negedge clock);
   endtask

   // Drop valid, wait for every outstanding pixel, then let the pipe empty
   task automatic settle_block();
      int waited;
      req_ch.valid = 1'b0;
      waited = 0;
      while (expected_pixels_q.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (expected_pixels_q.size() != 0) begin
         report_mismatch("pixels never returned", 0, expected_pixels_q.size());
         expected_pixels_q.delete();
      end
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register while idle; called and returns at a falling edge
   task automatic csr_write(input logic [CsrAddrW-1:0] addr, input logic [CsrDataW-1:0] data);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = data;
      @(posedge clock);
      if (addr == CsrPalMode) mode_pal  = data[0];
      else                    width_reg = data[LwW-1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Drive response back-pressure: hold ready low for a random stretch
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_hold = pick_gap(rsp_stall_pct);
         if (rsp_hold > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Compare each returned pixel with the oldest prediction
   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pixels_q.size() == 0) begin
            report_mismatch("pixel with none outstanding", rsp_ch.luma, 0);
         end else begin
            want = expected_pixels_q.pop_front();
            if (rsp_ch.luma !== want.luma) report_mismatch("luma", rsp_ch.luma, want.luma);
            if (rsp_ch.chroma_u !== want.chroma_u)
               report_mismatch("chroma_u", rsp_ch.chroma_u, want.chroma_u);
            if (rsp_ch.chroma_v !== want.chroma_v)
               report_mismatch("chroma_v", rsp_ch.chroma_v, want.chroma_v);
         end
      end
   end

   // Fill both palettes; put full-scale and zero words where the directed pixels hit
   task automatic test_palette_load();
      logic [WordW-1:0] word;
      for (int half = 0; half < 2; half++) begin
         for (int entry = 0; entry < 16; entry++) begin
            case (entry)
               0:       word = (half == 0) ? 24'hFFFFFF : 24'h000000;
               1:       word = (half == 0) ? 24'h000000 : 24'hFFFFFF;
               2:       word = (half == 0) ? 24'hFF00FF : 24'h00FEFF;
               default: word = WordW'($urandom);
            endcase
            send_item(table_item(1'(half), IndexW'(entry), word));
         end
      end
   endtask

   // First line passes through, later lines average against the one above
   task automatic test_line_averaging();
      settle_block();
      csr_write(CsrLineWidth, 10'd3);
      send_item(pixel_item(4'd0, 1'b1));
      send_item(pixel_item(4'd1, 1'b0));
      send_item(pixel_item(4'd2, 1'b0));
      send_item(pixel_item(4'd0, 1'b0));
      send_item(pixel_item(4'd1, 1'b0));
      send_item(pixel_item(4'd2, 1'b0));
      send_item(pixel_item(4'd1, 1'b0));
      send_item(pixel_item(4'd0, 1'b0));
      send_item(pixel_item(4'd15, 1'b0));
   endtask

   // Non-PAL mode passes the lookup; the line store still advances
   task automatic test_bypass_mode();
      settle_block();
      csr_write(CsrPalMode, {9'h1FF, 1'b0});
      send_item(pixel_item(4'd0, 1'b0));
      send_item(pixel_item(4'd2, 1'b0));
      send_item(pixel_item(4'd1, 1'b0));
      settle_block();
      csr_write(CsrPalMode, {9'h000, 1'b1});
   endtask

   // Width zero acts as one, widths past the store clamp to it
   task automatic test_width_limits();
      settle_block();
      csr_write(CsrLineWidth, 10'd0);
      send_item(pixel_item(4'd0, 1'b0));
      send_item(pixel_item(4'd1, 1'b0));
      send_item(pixel_item(4'd2, 1'b0));
      settle_block();
      csr_write(CsrLineWidth, 10'd1023);
      send_item(pixel_item(4'd15, 1'b0));
      send_item(pixel_item(4'd0, 1'b0));
   endtask

   // Shrink the width mid-line: the line ends at the next pixel; a palette write
   // in between leaves the position alone
   task automatic test_width_shrink();
      settle_block();
      csr_write(CsrLineWidth, 10'd6);
      send_item(pixel_item(4'd1, 1'b1));
      send_item(pixel_item(4'd2, 1'b0));
      send_item(table_item(1'b0, 4'd3, 24'h80FF00));
      send_item(pixel_item(4'd3, 1'b0));
      send_item(pixel_item(4'd0, 1'b0));
      settle_block();
      csr_write(CsrLineWidth, 10'd2);
      send_item(pixel_item(4'd3, 1'b0));
      send_item(pixel_item(4'd1, 1'b0));
   endtask

   // Random phases: mostly pixel runs across many lines, with frame starts,
   // palette rewrites and changing settings between phases
   task automatic test_random_traffic();
      int               pick;
      int               count;
      logic [CsrDataW-1:0] width;
      logic [WordW-1:0] word;
      for (int phase = 0; phase < 10; phase++) begin
         settle_block();
         case ($urandom_range(9))
            0:       width = 10'd0;
            1:       width = 10'd1;
            2:       width = 10'd512;
            3:       width = CsrDataW'($urandom_range(1023, 513));
            4:       width = LineWidthReset;
            default: width = CsrDataW'($urandom_range(16, 2));
         endcase
         csr_write(CsrLineWidth, width);
         csr_write(CsrPalMode, CsrDataW'($urandom));
         // Run every third phase at full rate on both sides
         if (phase % 3 == 0) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end else begin
            req_idle_pct  = $urandom_range(50, 10);
            rsp_stall_pct = $urandom_range(50, 10);
         end
         count = $urandom_range(200, 100);
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
               send_item(pixel_item(IndexW'($urandom), 1'b1));
            end else if (pick < 10) begin
               send_item(table_item(1'($urandom), IndexW'($urandom), WordW'($urandom)));
            end else if (pick < 12) begin
               word = {$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                       $urandom_range(1) ? 8'hFF : 8'h00};
               send_item(table_item(1'($urandom), IndexW'($urandom), word));
            end else begin
               send_item(pixel_item(IndexW'($urandom), 1'b0));
            end
         end
      end
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      req_idle_pct  = 20;
      rsp_stall_pct = 20;
      test_palette_load();
      test_line_averaging();
      test_bypass_mode();
      test_width_limits();
      test_width_shrink();
      test_random_traffic();
      settle_block();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
